// ===== sv/phasor_adder_unit_defines.svh =====
// Assertion macros shared by the phasor adder verification code.
`ifndef PHASOR_ADDER_UNIT_DEFINES_SVH
`define PHASOR_ADDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pau_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table of the phasor adder.
package pau_pkg;

   // default field widths and iteration count
   localparam int AMP_BITS_DEF      = 16;
   localparam int PHASE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // extra fraction bits carried on the vector components
   localparam int GUARD = 16;

   // round(2^32 / K^2), removes the gain of both CORDIC passes
   localparam logic [31:0] INVK2 = 32'd1583795506;

   // pi on the 32-bit angle scale
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // sideband flags for a sum that lies on the real axis
   typedef struct packed {
      logic neg_axis;
      logic pos_axis;
   } axis_type;

   // component width: amplitude, guard bits, gain growth of both passes, sign
   function automatic int vec_width(input int amp_bits);
      int w;
      w = amp_bits + GUARD + 5;
      return (w > 33) ? w : 33;
   endfunction

   // atan(2^-i) with 2^31 = pi
   function automatic logic [31:0] atan_step(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:    a = 32'h2000_0000;
         5'd1:    a = 32'h12E4_051E;
         5'd2:    a = 32'h09FB_385B;
         5'd3:    a = 32'h0511_11D4;
         5'd4:    a = 32'h028B_0D43;
         5'd5:    a = 32'h0145_D7E1;
         5'd6:    a = 32'h00A2_F61E;
         5'd7:    a = 32'h0051_7C55;
         5'd8:    a = 32'h0028_BE53;
         5'd9:    a = 32'h0014_5F2F;
         5'd10:   a = 32'h000A_2F98;
         5'd11:   a = 32'h0005_17CC;
         5'd12:   a = 32'h0002_8BE6;
         5'd13:   a = 32'h0001_45F3;
         5'd14:   a = 32'h0000_A2FA;
         5'd15:   a = 32'h0000_517D;
         5'd16:   a = 32'h0000_28BE;
         5'd17:   a = 32'h0000_145F;
         5'd18:   a = 32'h0000_0A30;
         5'd19:   a = 32'h0000_0518;
         5'd20:   a = 32'h0000_028C;
         5'd21:   a = 32'h0000_0146;
         5'd22:   a = 32'h0000_00A3;
         5'd23:   a = 32'h0000_0051;
         5'd24:   a = 32'h0000_0029;
         5'd25:   a = 32'h0000_0014;
         5'd26:   a = 32'h0000_000A;
         5'd27:   a = 32'h0000_0005;
         5'd28:   a = 32'h0000_0003;
         5'd29:   a = 32'h0000_0001;
         5'd30:   a = 32'h0000_0001;
         5'd31:   a = 32'h0000_0000;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/pau_rotate.sv =====
// Rotation-mode CORDIC pipeline: both polar operands to rectangular form.
module pau_rotate #(
   parameter int AMP_BITS      = pau_pkg::AMP_BITS_DEF,
   parameter int PHASE_BITS    = pau_pkg::PHASE_BITS_DEF,
   parameter int CORDIC_STAGES = pau_pkg::CORDIC_STAGES_DEF,
   localparam int W            = pau_pkg::vec_width(AMP_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [AMP_BITS-1:0]          in_amp_a,
   input  logic signed [PHASE_BITS-1:0] in_phase_a,
   input  logic [AMP_BITS-1:0]          in_amp_b,
   input  logic signed [PHASE_BITS-1:0] in_phase_b,
   output logic                         out_valid,
   input  logic                         out_stall,
   output logic [W-1:0]                 out_xa,
   output logic [W-1:0]                 out_ya,
   output logic [W-1:0]                 out_xb,
   output logic [W-1:0]                 out_yb
);

   localparam int S = CORDIC_STAGES;

   typedef struct packed {
      logic [W-1:0] x;
      logic [W-1:0] y;
      logic [31:0]  z;
   } lane_type;

   logic [S:0]   valid_ff;
   logic [S+1:0] adv;
   lane_type     a_ff [0:S];
   lane_type     b_ff [0:S];

   // start vector on the x axis, folded into the right half plane
   function automatic lane_type pre_rot(input logic [AMP_BITS-1:0] amp,
                                        input logic signed [PHASE_BITS-1:0] phase);
      lane_type r;
      r.x = W'(amp) << pau_pkg::GUARD;
      r.y = '0;
      r.z = 32'(phase) << (32 - PHASE_BITS);
      if (r.z[31] != r.z[30]) begin
         r.x = -r.x;
         r.z = r.z ^ pau_pkg::HALF_TURN;
      end
      return r;
   endfunction

   // one micro-rotation, driven by the sign of the residual angle
   function automatic lane_type rot_iter(input lane_type v, input int unsigned sh);
      lane_type     r;
      logic [W-1:0] dx;
      logic [W-1:0] dy;
      logic [31:0]  ang;
      dx  = W'($signed(v.y) >>> sh);
      dy  = W'($signed(v.x) >>> sh);
      ang = pau_pkg::atan_step(5'(sh));
      if (!v.z[31]) begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - ang;
      end else begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + ang;
      end
      return r;
   endfunction

   // a stage moves when it is empty or the stage after it moves
   assign adv[S+1] = !out_stall;
   for (genvar k = 0; k <= S; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign in_stall = !adv[0];

   // stage 0: quadrant fold
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff[0] <= pre_rot(in_amp_a, in_phase_a);
         b_ff[0] <= pre_rot(in_amp_b, in_phase_b);
      end
   end

   // one iteration per stage
   for (genvar k = 1; k <= S; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            a_ff[k] <= rot_iter(a_ff[k-1], k - 1);
            b_ff[k] <= rot_iter(b_ff[k-1], k - 1);
         end
      end
   end

   assign out_valid = valid_ff[S];
   assign out_xa    = a_ff[S].x;
   assign out_ya    = a_ff[S].y;
   assign out_xb    = b_ff[S].x;
   assign out_yb    = b_ff[S].y;

endmodule

// ===== sv/pau_vector.sv =====
// Vector sum and vectoring-mode CORDIC pipeline: sum back to magnitude and angle.
module pau_vector #(
   parameter int AMP_BITS      = pau_pkg::AMP_BITS_DEF,
   parameter int CORDIC_STAGES = pau_pkg::CORDIC_STAGES_DEF,
   localparam int W            = pau_pkg::vec_width(AMP_BITS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  logic [W-1:0]       in_xa,
   input  logic [W-1:0]       in_ya,
   input  logic [W-1:0]       in_xb,
   input  logic [W-1:0]       in_yb,
   output logic               out_valid,
   input  logic               out_stall,
   output logic [W-1:0]       out_x,
   output logic [31:0]        out_z,
   output pau_pkg::axis_type  out_axis
);

   localparam int S    = CORDIC_STAGES;
   localparam int LAST = S + 1;

   typedef struct packed {
      logic [W-1:0] x;
      logic [W-1:0] y;
      logic [31:0]  z;
   } lane_type;

   logic [LAST:0]     valid_ff;
   logic [LAST+1:0]   adv;
   lane_type          v_ff    [0:LAST];
   pau_pkg::axis_type axis_ff [1:LAST];
   lane_type          init_in;
   pau_pkg::axis_type axis_in;

   // one micro-rotation toward the positive x axis
   function automatic lane_type vec_iter(input lane_type v, input int unsigned sh);
      lane_type     r;
      logic [W-1:0] dx;
      logic [W-1:0] dy;
      logic [31:0]  ang;
      dx  = W'($signed(v.y) >>> sh);
      dy  = W'($signed(v.x) >>> sh);
      ang = pau_pkg::atan_step(5'(sh));
      if (!v.y[W-1]) begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + ang;
      end else begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - ang;
      end
      return r;
   endfunction

   assign adv[LAST+1] = !out_stall;
   for (genvar k = 0; k <= LAST; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign in_stall = !adv[0];

   // stage 0: add the two vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         v_ff[0].x <= in_xa + in_xb;
         v_ff[0].y <= in_ya + in_yb;
         v_ff[0].z <= '0;
      end
   end

   // stage 1: real-axis flags, fold left half plane by adding pi
   always_comb begin
      axis_in.neg_axis = (v_ff[0].y == '0) && v_ff[0].x[W-1];
      axis_in.pos_axis = (v_ff[0].y == '0) && !v_ff[0].x[W-1];
      init_in.x = v_ff[0].x;
      init_in.y = v_ff[0].y;
      init_in.z = '0;
      if (v_ff[0].x[W-1]) begin
         init_in.x = -v_ff[0].x;
         init_in.y = -v_ff[0].y;
         init_in.z = pau_pkg::HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[1] <= 1'b0;
      end else if (adv[1]) begin
         valid_ff[1] <= valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         v_ff[1]    <= init_in;
         axis_ff[1] <= axis_in;
      end
   end

   // one iteration per stage
   for (genvar k = 2; k <= LAST; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            v_ff[k]    <= vec_iter(v_ff[k-1], k - 2);
            axis_ff[k] <= axis_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_x     = v_ff[LAST].x;
   assign out_z     = v_ff[LAST].z;
   assign out_axis  = axis_ff[LAST];

endmodule

// ===== sv/pau_gain.sv =====
// Gain removal, amplitude rounding and saturation, phase rounding; output register.
module pau_gain #(
   parameter int AMP_BITS      = pau_pkg::AMP_BITS_DEF,
   parameter int PHASE_BITS    = pau_pkg::PHASE_BITS_DEF,
   localparam int W            = pau_pkg::vec_width(AMP_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [W-1:0]                 in_x,
   input  logic [31:0]                  in_z,
   input  pau_pkg::axis_type            in_axis,
   output logic                         out_valid,
   input  logic                         out_stall,
   output logic [AMP_BITS:0]            out_amp,
   output logic signed [PHASE_BITS-1:0] out_phase
);

   localparam int TW = W + 1;
   localparam logic [TW-1:0] ROUND = TW'(1) << (pau_pkg::GUARD - 1);

   logic [1:0]            valid_ff;
   logic [2:0]            adv;
   logic [63:0]           lo_prod_ff;
   logic [W-1:0]          hi_prod_ff;
   logic [PHASE_BITS-1:0] pc_ff;
   logic [AMP_BITS:0]     amp_ff;
   logic [PHASE_BITS-1:0] phase_ff;

   logic [63:0]           lo_prod_in;
   logic [W-1:0]          hi_prod_in;
   logic [31:0]           z_rnd;
   logic [PHASE_BITS-1:0] pc_in;
   logic [TW-1:0]         t_sum;
   logic [W-pau_pkg::GUARD:0] amp_wide;
   logic [AMP_BITS:0]     amp_in;

   assign adv[2] = !out_stall;
   assign adv[1] = !valid_ff[1] || adv[2];
   assign adv[0] = !valid_ff[0] || adv[1];
   assign in_stall = !adv[0];

   // magnitude times 1/K^2, split at bit 32 into two partial products
   assign lo_prod_in = 64'(in_x[31:0]) * 64'(pau_pkg::INVK2);
   assign hi_prod_in = W'(in_x[W-1:32]) * W'(pau_pkg::INVK2);

   // angle rounded to the phase code by half an LSB (no rounding when PHASE_BITS is 32)
   if (PHASE_BITS == 32) begin : g_no_round
      assign z_rnd = in_z;
   end else begin : g_round
      assign z_rnd = in_z + (32'd1 << (31 - PHASE_BITS));
   end

   // real-axis sums take exact codes
   always_comb begin
      pc_in = z_rnd[31 -: PHASE_BITS];
      if (in_axis.neg_axis) begin
         pc_in = '0;
         pc_in[PHASE_BITS-1] = 1'b1;
      end
      if (in_axis.pos_axis) begin
         pc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         lo_prod_ff <= lo_prod_in;
         hi_prod_ff <= hi_prod_in;
         pc_ff      <= pc_in;
      end
   end

   // combine partial products, drop guard bits with rounding, saturate
   always_comb begin
      t_sum    = TW'(hi_prod_ff) + TW'(lo_prod_ff[63:32]) + ROUND;
      amp_wide = t_sum[TW-1:pau_pkg::GUARD];
      if (|amp_wide[W-pau_pkg::GUARD:AMP_BITS+1]) begin
         amp_in = '1;
      end else begin
         amp_in = amp_wide[AMP_BITS:0];
      end
   end

   // output register: holds the word while the far side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[1] <= 1'b0;
      end else if (adv[1]) begin
         valid_ff[1] <= valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         amp_ff   <= amp_in;
         phase_ff <= pc_ff;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_amp   = amp_ff;
   assign out_phase = $signed(phase_ff);

endmodule

// ===== sv/phasor_adder_unit.sv =====
// Phasor adder top level: sum of two equal-frequency sinusoids in polar form.
//
// Takes one word per clock while req_stall is low and returns one result word
// per input word, in order. Each word passes a rotation CORDIC (one pipeline
// stage per iteration, both operands side by side), a vector add, a vectoring
// CORDIC (again one stage per iteration) and a two-stage gain multiply whose
// second stage is the output register. Throughput is one word per cycle when
// the output is not stalled. Every stage moves on its own when empty, so while
// rsp_stall holds a finished word, new request words are still taken until the
// pipeline is full. Amplitudes are unsigned Q8.8 in and Q9.8 out, gain
// compensated, rounded, saturating at all ones; phases are signed fractions of
// pi, -2^(PHASE_BITS-1) meaning -pi. A sum on the negative real axis reports
// -pi, a zero sum reports amplitude 0, phase 0.
module phasor_adder_unit #(
   parameter int AMP_BITS      = pau_pkg::AMP_BITS_DEF,
   parameter int PHASE_BITS    = pau_pkg::PHASE_BITS_DEF,
   parameter int CORDIC_STAGES = pau_pkg::CORDIC_STAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [AMP_BITS-1:0]          req_amp_a,
   input  logic signed [PHASE_BITS-1:0] req_phase_a,
   input  logic [AMP_BITS-1:0]          req_amp_b,
   input  logic signed [PHASE_BITS-1:0] req_phase_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [AMP_BITS:0]            rsp_amp_sum,
   output logic signed [PHASE_BITS-1:0] rsp_phase_sum
);

   localparam int W = pau_pkg::vec_width(AMP_BITS);

   logic              rot_valid;
   logic              rot_stall;
   logic [W-1:0]      rot_xa;
   logic [W-1:0]      rot_ya;
   logic [W-1:0]      rot_xb;
   logic [W-1:0]      rot_yb;
   logic              vec_valid;
   logic              vec_stall;
   logic [W-1:0]      vec_x;
   logic [31:0]       vec_z;
   pau_pkg::axis_type vec_axis;

   // polar to rectangular, both operands
   pau_rotate #(
      .AMP_BITS      (AMP_BITS),
      .PHASE_BITS    (PHASE_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_amp_a   (req_amp_a),
      .in_phase_a (req_phase_a),
      .in_amp_b   (req_amp_b),
      .in_phase_b (req_phase_b),
      .out_valid  (rot_valid),
      .out_stall  (rot_stall),
      .out_xa     (rot_xa),
      .out_ya     (rot_ya),
      .out_xb     (rot_xb),
      .out_yb     (rot_yb)
   );

   // vector add, rectangular to polar
   pau_vector #(
      .AMP_BITS      (AMP_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_vector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_stall  (rot_stall),
      .in_xa     (rot_xa),
      .in_ya     (rot_ya),
      .in_xb     (rot_xb),
      .in_yb     (rot_yb),
      .out_valid (vec_valid),
      .out_stall (vec_stall),
      .out_x     (vec_x),
      .out_z     (vec_z),
      .out_axis  (vec_axis)
   );

   // gain removal and output formatting
   pau_gain #(
      .AMP_BITS   (AMP_BITS),
      .PHASE_BITS (PHASE_BITS)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vec_valid),
      .in_stall  (vec_stall),
      .in_x      (vec_x),
      .in_z      (vec_z),
      .in_axis   (vec_axis),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_amp   (rsp_amp_sum),
      .out_phase (rsp_phase_sum)
   );

endmodule

// ===== sv/pau_checker.sv =====
// Port-level checker for the phasor adder, bound to the top level.
`include "phasor_adder_unit_defines.svh"

module pau_checker #(
   parameter int AMP_BITS      = pau_pkg::AMP_BITS_DEF,
   parameter int PHASE_BITS    = pau_pkg::PHASE_BITS_DEF,
   parameter int CORDIC_STAGES = pau_pkg::CORDIC_STAGES_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [AMP_BITS:0]            rsp_amp_sum,
   input logic signed [PHASE_BITS-1:0] rsp_phase_sum
);

   // pipeline holds at most one word per register stage
   localparam int DEPTH = 2 * CORDIC_STAGES + 5;
   localparam int CW    = $clog2(DEPTH + 1) + 1;

   logic [CW-1:0] outstanding_ff;
   logic [CW-1:0] outstanding_in;
   logic          req_take;
   logic          rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // words taken but not yet delivered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + CW'(1);
      end else if (!req_take && rsp_take) begin
         outstanding_in = outstanding_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `PAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_amp_sum) && $stable(rsp_phase_sum), "stalled result word changed or dropped")
   `PAU_ASSERT_NOW(a_no_orphan, clock, reset, rsp_valid, outstanding_ff != '0, "result word without a request word")
   `PAU_ASSERT_NOW(a_depth, clock, reset, 1'b1, outstanding_ff <= CW'(DEPTH), "more words in flight than stages")
   `PAU_ASSERT_NOW(a_idle_ready, clock, reset, outstanding_ff == '0, !req_stall, "empty pipeline stalls requests")

endmodule

bind phasor_adder_unit pau_checker #(
   .AMP_BITS      (AMP_BITS),
   .PHASE_BITS    (PHASE_BITS),
   .CORDIC_STAGES (CORDIC_STAGES)
) u_pau_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_amp_sum   (rsp_amp_sum),
   .rsp_phase_sum (rsp_phase_sum)
);
